// File: src/fiw_pkg.sv
package fiw_pkg;

  // flash geometry
  localparam int SECTOR_BYTES = 4096;
  localparam int ADDRESS_BITS = 24;

  // port widths fixed by the interface
  localparam int OUT_ADDR_BITS = 24;
  localparam int SIZE_BITS     = 25;
  localparam int CRC_BITS      = 16;
  localparam int CFG_IDX_BITS  = 2;

  // reflected crc-16 polynomial
  localparam logic [CRC_BITS-1:0] CRC_POLY = 16'hA001;

  typedef enum logic [2:0] {
    ACT_ERASE    = 3'd0,
    ACT_WRITE    = 3'd1,
    ACT_MATCH    = 3'd2,
    ACT_MISMATCH = 3'd3,
    ACT_OVERRUN  = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_IMAGE_SIZE   = 2'd1,
    CFG_EXPECTED_CRC = 2'd2
  } cfg_index_t;

  typedef struct packed {
    action_t                  action;
    logic [OUT_ADDR_BITS-1:0] addr;
    logic [CRC_BITS-1:0]      value;
    logic                     last;
  } result_t;

  // fold one byte into the crc, lsb first
  function automatic logic [CRC_BITS-1:0] crc_fold(input logic [CRC_BITS-1:0] crc,
                                                   input logic [7:0] data);
    logic [CRC_BITS-1:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/firmware_image_flash_writer.sv
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+----------------------------------------
// in       | input     | in_valid / in_ready   | cmd, data_byte
// out      | output    | out_valid / out_ready | action, flash_address, result_value, last
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// An input word is held in one input register and is processed when the
// three-slot result buffer is empty or handing over its final word; one word per cycle.
// A word's results (erase, write, done at most) hold the buffer until they are all out, one
// per cycle while out_ready is high, and that sets the rate; start words make no result.
// Reset (rst, synchronous) clears the config registers, the progress state and both buffers.
// A stalled output holds its word; the input register holds one more word, then in_ready drops.
module firmware_image_flash_writer #(
  parameter int ADDRESS_BITS = fiw_pkg::ADDRESS_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic [7:0]                        data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        action,
  output logic [fiw_pkg::OUT_ADDR_BITS-1:0] flash_address,
  output logic [fiw_pkg::CRC_BITS-1:0]      result_value,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fiw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fiw_pkg::SIZE_BITS-1:0]     cfg_data
);

  localparam int AW = ADDRESS_BITS;

  // config registers
  logic [fiw_pkg::OUT_ADDR_BITS-1:0] base_address;
  logic [fiw_pkg::SIZE_BITS-1:0]     image_size;
  logic [fiw_pkg::CRC_BITS-1:0]      expected_crc;

  // progress state
  logic [AW-1:0]                 write_address, write_address_next;
  logic [AW-1:0]                 erase_boundary, erase_boundary_next;
  logic [fiw_pkg::SIZE_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [fiw_pkg::CRC_BITS-1:0]  crc_value, crc_value_next;

  // input register
  logic       in_full;
  logic       in_cmd;
  logic [7:0] in_byte;

  // result buffer, slot 0 drives the output
  fiw_pkg::result_t slot0, slot1, slot2;
  fiw_pkg::result_t res0, res1, res2;
  logic [1:0]       count;
  logic [1:0]       res_count;

  logic                          consume;
  logic [AW-1:0]                 base_aw;
  logic [fiw_pkg::CRC_BITS-1:0]  crc_new;
  logic                          erase_hit;
  logic                          done_hit;
  fiw_pkg::result_t              erase_r, write_r, done_r, overrun_r;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      image_size   <= '0;
      expected_crc <= '0;
    end else if (cfg_valid) begin
      case (fiw_pkg::cfg_index_t'(cfg_index))
        fiw_pkg::CFG_BASE_ADDRESS: base_address <= cfg_data[fiw_pkg::OUT_ADDR_BITS-1:0];
        fiw_pkg::CFG_IMAGE_SIZE:   image_size   <= cfg_data;
        fiw_pkg::CFG_EXPECTED_CRC: expected_crc <= cfg_data[fiw_pkg::CRC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // process the held word when the buffer frees up this cycle
  assign consume  = in_full && ((count == 2'd0) || ((count == 2'd1) && out_ready));
  assign in_ready = !in_full || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cmd  <= cmd;
      in_byte <= data_byte;
    end
  end

  // candidate result words
  assign base_aw   = AW'(32'(base_address));
  assign crc_new   = fiw_pkg::crc_fold(crc_value, in_byte);
  assign erase_hit = (write_address == erase_boundary);
  assign done_hit  = (bytes_remaining == fiw_pkg::SIZE_BITS'(1));

  always_comb begin
    erase_r.action   = fiw_pkg::ACT_ERASE;
    erase_r.addr     = fiw_pkg::OUT_ADDR_BITS'(32'(erase_boundary));
    erase_r.value    = '0;
    erase_r.last     = 1'b0;
    write_r.action   = fiw_pkg::ACT_WRITE;
    write_r.addr     = fiw_pkg::OUT_ADDR_BITS'(32'(write_address));
    write_r.value    = {8'h00, in_byte};
    write_r.last     = !done_hit;
    done_r.action    = (crc_new == expected_crc) ? fiw_pkg::ACT_MATCH : fiw_pkg::ACT_MISMATCH;
    done_r.addr      = '0;
    done_r.value     = crc_new;
    done_r.last      = 1'b1;
    overrun_r.action = fiw_pkg::ACT_OVERRUN;
    overrun_r.addr   = fiw_pkg::OUT_ADDR_BITS'(32'(write_address));
    overrun_r.value  = {8'h00, in_byte};
    overrun_r.last   = 1'b1;
  end

  // next progress state and the results of the held word
  always_comb begin
    write_address_next   = write_address;
    erase_boundary_next  = erase_boundary;
    bytes_remaining_next = bytes_remaining;
    crc_value_next       = crc_value;
    res0                 = write_r;
    res1                 = done_r;
    res2                 = done_r;
    res_count            = 2'd0;
    if (consume) begin
      if (!in_cmd) begin
        write_address_next   = base_aw;
        erase_boundary_next  = base_aw;
        bytes_remaining_next = image_size;
        crc_value_next       = '0;
      end else if (bytes_remaining == '0) begin
        res0      = overrun_r;
        res_count = 2'd1;
      end else begin
        write_address_next   = write_address + AW'(1);
        bytes_remaining_next = bytes_remaining - fiw_pkg::SIZE_BITS'(1);
        crc_value_next       = crc_new;
        if (erase_hit) begin
          erase_boundary_next = erase_boundary + AW'(fiw_pkg::SECTOR_BYTES);
          res0                = erase_r;
          res1                = write_r;
          res_count           = done_hit ? 2'd3 : 2'd2;
        end else begin
          res_count = done_hit ? 2'd2 : 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_address   <= '0;
      erase_boundary  <= '0;
      bytes_remaining <= '0;
      crc_value       <= '0;
    end else begin
      write_address   <= write_address_next;
      erase_boundary  <= erase_boundary_next;
      bytes_remaining <= bytes_remaining_next;
      crc_value       <= crc_value_next;
    end
  end

  // result buffer: load on consume, else shift down on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (consume) begin
      count <= res_count;
    end else if (out_valid && out_ready) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      slot0 <= res0;
      slot1 <= res1;
      slot2 <= res2;
    end else if (out_valid && out_ready) begin
      slot0 <= slot1;
      slot1 <= slot2;
    end
  end

  assign out_valid     = (count != 2'd0);
  assign action        = slot0.action;
  assign flash_address = slot0.addr;
  assign result_value  = slot0.value;
  assign last          = slot0.last;

`ifndef ASSERT_OFF
  // the final buffered word closes its group
  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> slot0.last)
    else $error("final buffered word lacks last");

  // a word is only taken into processing into a free buffer
  a_consume_free: assert property (@(posedge clk) disable iff (rst)
    consume |-> ((count == 2'd0) || (out_valid && out_ready)))
    else $error("buffer overwritten before drained");

  // an in-image byte advances address and count by one
  a_byte_advance: assert property (@(posedge clk) disable iff (rst)
    (consume && in_cmd && (bytes_remaining != '0)) |=>
      ((write_address == $past(write_address) + AW'(1)) &&
       (bytes_remaining == $past(bytes_remaining) - fiw_pkg::SIZE_BITS'(1))))
    else $error("byte did not advance progress");

  // an overrun byte leaves the progress untouched
  a_overrun_hold: assert property (@(posedge clk) disable iff (rst)
    (consume && in_cmd && (bytes_remaining == '0)) |=>
      ((bytes_remaining == '0) && $stable(write_address) && $stable(crc_value)))
    else $error("overrun changed progress");
`endif

endmodule

// File: test/tb_firmware_image_flash_writer.sv
module tb_firmware_image_flash_writer;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;
  localparam logic [fiw_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic [7:0] data_byte;
  logic out_valid;
  logic out_ready;
  logic [2:0] action;
  logic [fiw_pkg::OUT_ADDR_BITS-1:0] flash_address;
  logic [fiw_pkg::CRC_BITS-1:0] result_value;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [fiw_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [fiw_pkg::SIZE_BITS-1:0] cfg_data;

  // register copies and progress of the image in flight
  logic [fiw_pkg::ADDRESS_BITS-1:0] cfg_base = '0;
  logic [fiw_pkg::SIZE_BITS-1:0] cfg_size = '0;
  logic [fiw_pkg::CRC_BITS-1:0] cfg_crc = '0;
  logic [fiw_pkg::ADDRESS_BITS-1:0] wr_addr = '0;
  logic [fiw_pkg::ADDRESS_BITS-1:0] erase_at = '0;
  logic [fiw_pkg::SIZE_BITS-1:0] bytes_left = '0;
  logic [fiw_pkg::CRC_BITS-1:0] crc_acc = '0;

  fiw_pkg::result_t flash_ops_due[$];
  int errors = 0;
  int words_sent = 0;
  int cycle_count = 0;
  int sender_idle_pct;
  int receiver_idle_pct;

  firmware_image_flash_writer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action(action),
    .flash_address(flash_address),
    .result_value(result_value),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // reflected crc-16, one byte lsb first
  function automatic logic [fiw_pkg::CRC_BITS-1:0] crc16_byte(
      input logic [fiw_pkg::CRC_BITS-1:0] acc, input logic [7:0] d);
    logic [fiw_pkg::CRC_BITS-1:0] r;
    logic lsb;
    r = acc ^ {8'h00, d};
    repeat (8) begin
      lsb = r[0];
      r = {1'b0, r[fiw_pkg::CRC_BITS-1:1]};
      if (lsb) r = r ^ fiw_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic logic [fiw_pkg::CRC_BITS-1:0] image_crc(input logic [7:0] img[]);
    logic [fiw_pkg::CRC_BITS-1:0] acc;
    acc = '0;
    foreach (img[i]) acc = crc16_byte(acc, img[i]);
    return acc;
  endfunction

  // flash operations caused by one accepted word
  function automatic void plan_flash_ops(input logic c, input logic [7:0] b);
    fiw_pkg::result_t ops[3];
    fiw_pkg::action_t done_act;
    int n;
    n = 0;
    if (c == CMD_START) begin
      wr_addr = cfg_base;
      erase_at = cfg_base;
      bytes_left = cfg_size;
      crc_acc = '0;
      return;
    end
    if (bytes_left == 0) begin
      ops[0] = '{fiw_pkg::ACT_OVERRUN, wr_addr, {8'h00, b}, 1'b0};
      n = 1;
    end else begin
      if (wr_addr == erase_at) begin
        ops[n] = '{fiw_pkg::ACT_ERASE, erase_at, '0, 1'b0};
        n++;
        erase_at = erase_at + fiw_pkg::ADDRESS_BITS'(fiw_pkg::SECTOR_BYTES);
      end
      ops[n] = '{fiw_pkg::ACT_WRITE, wr_addr, {8'h00, b}, 1'b0};
      n++;
      wr_addr = wr_addr + 1'b1;
      crc_acc = crc16_byte(crc_acc, b);
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == 0) begin
        done_act = fiw_pkg::ACT_MISMATCH;
        if (crc_acc == cfg_crc) done_act = fiw_pkg::ACT_MATCH;
        ops[n] = '{done_act, '0, crc_acc, 1'b0};
        n++;
      end
    end
    ops[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) flash_ops_due.push_back(ops[i]);
  endfunction

  function automatic void check_field(input string what, input logic [23:0] want,
                                      input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // receiver stalls
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // compare each result word with the oldest expected one
  always @(posedge clk) begin
    fiw_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (flash_ops_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual action %0d addr %0h",
                 $time, action, flash_address);
        $display("%0t: unexpected result, actual value %0h last %0b",
                 $time, result_value, last);
      end else begin
        want = flash_ops_due.pop_front();
        check_field("action", 24'(want.action), 24'(action));
        check_field("flash_address", want.addr, flash_address);
        check_field("result_value", 24'(want.value), 24'(result_value));
        check_field("last", 24'(want.last), 24'(last));
      end
    end
  end

  // send one word, with a random gap in front
  task automatic send_word(input logic c, input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    plan_flash_ops(c, b);
    words_sent++;
    @(negedge clk);
  endtask

  // stop sending until every expected result is out, then let the block settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (flash_ops_due.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // write all registers while idle, optionally also the unused index
  task automatic set_config(input logic [23:0] base, input logic [fiw_pkg::SIZE_BITS-1:0] size,
                            input logic [fiw_pkg::CRC_BITS-1:0] crc, input bit with_unused);
    logic [fiw_pkg::CFG_IDX_BITS-1:0] idx;
    logic [fiw_pkg::SIZE_BITS-1:0] val;
    drain(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    for (int i = 0; i < (with_unused ? 4 : 3); i++) begin
      case (i)
        0: begin
          idx = fiw_pkg::CFG_BASE_ADDRESS;
          val = {1'b0, base};
        end
        1: begin
          idx = fiw_pkg::CFG_IMAGE_SIZE;
          val = size;
        end
        2: begin
          idx = fiw_pkg::CFG_EXPECTED_CRC;
          val = {9'h000, crc};
        end
        default: begin
          idx = CFG_UNUSED;
          val = fiw_pkg::SIZE_BITS'($urandom);
        end
      endcase
      cfg_index <= idx;
      cfg_data <= val;
      do @(posedge clk); while (!cfg_ready);
      case (idx)
        fiw_pkg::CFG_BASE_ADDRESS: cfg_base = val[23:0];
        fiw_pkg::CFG_IMAGE_SIZE:   cfg_size = val;
        fiw_pkg::CFG_EXPECTED_CRC: cfg_crc = val[fiw_pkg::CRC_BITS-1:0];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // bytes before any start, then a start with the reset registers
  task automatic test_before_start();
    send_word(CMD_DATA, 8'h00);
    send_word(CMD_DATA, 8'hFF);
    send_word(CMD_START, 8'hFF);
    send_word(CMD_DATA, 8'($urandom));
  endtask

  task automatic test_empty_image();
    set_config(24'h123000, '0, '0, 1'b0);
    send_word(CMD_START, 8'h00);
    send_word(CMD_DATA, 8'hA5);
  endtask

  // good crc, a pause until all results are out, then an overrun byte
  task automatic test_crc_match();
    logic [7:0] img[];
    img = '{8'h00, 8'hFF, 8'h5A};
    set_config('0, fiw_pkg::SIZE_BITS'(3), image_crc(img), 1'b0);
    send_word(CMD_START, 8'($urandom));
    send_word(CMD_DATA, img[0]);
    drain(0);
    send_word(CMD_DATA, img[1]);
    send_word(CMD_DATA, img[2]);
    send_word(CMD_DATA, 8'h33);
  endtask

  // unaligned base just below a sector end, then a restart after the image and one byte more
  task automatic test_crc_mismatch();
    set_config(24'h000FFE, fiw_pkg::SIZE_BITS'(3), 16'hFFFF, 1'b0);
    send_word(CMD_START, 8'($urandom));
    repeat (3) send_word(CMD_DATA, 8'($urandom));
    send_word(CMD_START, 8'($urandom));
    send_word(CMD_DATA, 8'($urandom));
  endtask

  task automatic test_address_wrap();
    set_config(24'hFFFFFE, fiw_pkg::SIZE_BITS'(4), fiw_pkg::CRC_BITS'($urandom), 1'b0);
    send_word(CMD_START, 8'($urandom));
    repeat (4) send_word(CMD_DATA, 8'($urandom));
  endtask

  // largest image size, never finished
  task automatic test_oversized_size();
    set_config(24'h7FF000, {fiw_pkg::SIZE_BITS{1'b1}}, '0, 1'b1);
    send_word(CMD_START, 8'($urandom));
    repeat (3) send_word(CMD_DATA, 8'($urandom));
  endtask

  // random images, mostly well formed, some cut short, overrun or restarted
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int quota);
    int goal;
    int img_len;
    int mode;
    int cut;
    int k;
    logic [11:0] sector_num;
    logic [23:0] base;
    logic [fiw_pkg::CRC_BITS-1:0] want_crc;
    logic [7:0] img[];
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    goal = words_sent + quota;
    while (words_sent < goal) begin
      case ($urandom_range(0, 19))
        0: img_len = 0;
        1, 2: img_len = $urandom_range(13, 40);
        default: img_len = $urandom_range(1, 12);
      endcase
      sector_num = 12'($urandom);
      case ($urandom_range(0, 3))
        0: base = {sector_num, 12'h000};
        1: begin
          base = {sector_num, 12'hFFF};
          base = base - 24'($urandom_range(0, 6));
        end
        2: base = 24'hFFFFFF - 24'($urandom_range(0, 8));
        default: base = 24'($urandom);
      endcase
      img = new[img_len];
      foreach (img[i]) img[i] = 8'($urandom);
      want_crc = image_crc(img);
      if ($urandom_range(0, 1)) want_crc = fiw_pkg::CRC_BITS'($urandom);
      set_config(base, fiw_pkg::SIZE_BITS'(img_len), want_crc, 1'b0);
      send_word(CMD_START, 8'($urandom));
      mode = $urandom_range(0, 9);
      cut = img_len;
      if (mode == 0 && img_len > 0) cut = $urandom_range(0, img_len - 1);
      // stray restart partway in
      if (mode == 2 && img_len > 0) begin
        k = $urandom_range(0, img_len - 1);
        for (int i = 0; i < k; i++) send_word(CMD_DATA, img[i]);
        send_word(CMD_START, 8'($urandom));
      end
      for (int i = 0; i < cut; i++) begin
        if (mode == 3 && i == cut / 2) drain(0);
        send_word(CMD_DATA, img[i]);
      end
      if (mode == 1) repeat ($urandom_range(1, 3)) send_word(CMD_DATA, 8'($urandom));
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= CMD_START;
    data_byte <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= fiw_pkg::CFG_BASE_ADDRESS;
    cfg_data <= '0;
    sender_idle_pct = 31;
    receiver_idle_pct = 46;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_before_start();
    test_empty_image();
    test_crc_match();
    test_crc_mismatch();
    test_address_wrap();
    test_oversized_size();
    run_random_phase(31, 46, 95);
    run_random_phase(46, 31, 95);
    run_random_phase(0, 0, 90);

    drain(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
src/fiw_pkg.sv
src/firmware_image_flash_writer.sv
test/tb_firmware_image_flash_writer.sv
